@@ rtl/quad_element_strain_energy_assert.svh @@
// Assertion macros for the strain energy block
`ifndef QUAD_ELEMENT_STRAIN_ENERGY_ASSERT_SVH
`define QUAD_ELEMENT_STRAIN_ENERGY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define QESE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define QESE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers reset
`define QESE_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/qese_pkg.sv @@
package qese_pkg;

    localparam int IN_W          = 32;
    localparam int STRAIN_W      = 48;
    localparam int ENERGY_W      = 63;
    localparam int CFG_IDX_W     = 2;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR  = 2'd2;

    // 1/sqrt(3) in Q0.28
    localparam logic signed [63:0] G28 = 64'sd154981283;

endpackage

@@ rtl/quad_element_strain_energy.sv @@
// Strain energy density of one bilinear quad element, plane strain.
//
// Input: one node per request, taken at a clock edge with start high and busy
// low (node_x, node_y, disp_x, disp_y, last_of_mesh). The first three nodes of
// an element are stored and busy stays low. The fourth node
// starts the element evaluation and busy stays high until the result is out.
// Evaluation runs on one 32x32 multiplier (a 64x64 product takes four passes)
// and one radix-2 divider, 160 steps per quotient, under a micro-op sequencer.
// After the fourth node the sequencer forms the shape terms, then runs each of
// the four Gauss points (a point with zero determinant skips the divisions and
// marks the element degenerate), then forms the energy.
// Result: strain_xx, strain_yy, energy_density, degenerate and mesh_done are
// valid for one cycle with o_valid high; busy drops in that same cycle. The
// receiver cannot stall and must take the result then.
// Configuration: write stiffness registers with i_cfg_we while busy is low.
// Reset clears the node counter, the stiffness registers and the sequencer.
module quad_element_strain_energy
    import qese_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [IN_W-1:0]      i_node_x,
    input  logic signed [IN_W-1:0]      i_node_y,
    input  logic signed [IN_W-1:0]      i_disp_x,
    input  logic signed [IN_W-1:0]      i_disp_y,
    input  logic                        i_last_of_mesh,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [IN_W-1:0]             i_cfg_wdata,
    output logic                        o_valid,
    output logic signed [STRAIN_W-1:0]  o_strain_xx,
    output logic signed [STRAIN_W-1:0]  o_strain_yy,
    output logic [ENERGY_W-1:0]         o_energy_density,
    output logic                        o_degenerate,
    output logic                        o_mesh_done
);

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_MUL, S_AFTER, S_DIV, S_DACC, S_AVG
    } t_state;

    typedef enum logic [4:0] {
        OP_GQ0, OP_GQ1, OP_GQ2, OP_GQ3,
        OP_DET0, OP_DET1,
        OP_NXX0, OP_NXX1, OP_NYY0, OP_NYY1,
        OP_NG0, OP_NG1, OP_NG2, OP_NG3,
        OP_SQXX, OP_SQYY, OP_SQXY, OP_SQG,
        OP_EN0, OP_EN1, OP_EN2, OP_EN3, OP_EN4
    } t_op;

    localparam logic [61:0] GP_LIM = 62'd1 << 60;
    localparam logic signed [63:0] S48_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] S48_MIN = -64'sd140737488355328;

    t_state r_state;
    t_op    r_op;
    logic [1:0] r_cnt;
    logic [1:0] r_pt;
    logic       r_last, r_degen, r_valid;

    logic signed [IN_W-1:0] r_nv [4][4];
    logic signed [IN_W-1:0] r_d11, r_d12, r_d33;
    logic signed [63:0] r_gq [4];
    logic signed [63:0] r_t [4];
    logic signed [63:0] r_sxx, r_syy, r_sg;
    logic signed [STRAIN_W-1:0] r_exx, r_eyy, r_gxy;

    logic [63:0]  r_ma, r_mb;
    logic         r_msg;
    logic [2:0]   r_pc;
    logic [63:0]  r_pp;
    logic [1:0]   r_psh;
    logic [127:0] r_acc, r_det;

    logic [127:0] r_dn, r_dd, r_dr;
    logic [61:0]  r_dq;
    logic         r_dsat, r_dneg;
    logic [7:0]   r_dk;

    logic signed [STRAIN_W-1:0] r_oxx, r_oyy;
    logic [ENERGY_W-1:0]        r_oen;
    logic                       r_odeg, r_odone;

    logic signed [33:0] bxi [4];
    logic signed [33:0] beta [4];
    logic signed [33:0] tw [4];
    logic signed [63:0] dxi [4];
    logic signed [63:0] deta [4];

    logic signed [63:0] m_a, m_b;
    logic m_sub, m_clr;

    logic [31:0]  pa, pb;
    logic [127:0] pext, padd;
    logic [128:0] d_r2, d_sub;
    logic         d_ge;
    logic [61:0]  d_qn;
    logic [63:0]  d_qs;
    logic signed [127:0] tot_sh;
    logic [ENERGY_W-1:0] energy;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [STRAIN_W-1:0] sat48(input logic signed [63:0] s);
        logic signed [63:0] q;
        q = s >>> 2;
        if (q > S48_MAX) begin
            q = S48_MAX;
        end else if (q < S48_MIN) begin
            q = S48_MIN;
        end
        return q[STRAIN_W-1:0];
    endfunction

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_strain_xx      = r_oxx;
    assign o_strain_yy      = r_oyy;
    assign o_energy_density = r_oen;
    assign o_degenerate     = r_odeg;
    assign o_mesh_done      = r_odone;

    always_comb begin
        for (int v = 0; v < 4; v++) begin
            bxi[v]  = -34'(r_nv[v][0]) + 34'(r_nv[v][1]) + 34'(r_nv[v][2]) - 34'(r_nv[v][3]);
            beta[v] = -34'(r_nv[v][0]) - 34'(r_nv[v][1]) + 34'(r_nv[v][2]) + 34'(r_nv[v][3]);
            tw[v]   = 34'(r_nv[v][0]) - 34'(r_nv[v][1]) + 34'(r_nv[v][2]) - 34'(r_nv[v][3]);
            dxi[v]  = $signed({{2{bxi[v][33]}}, bxi[v], 28'd0})
                    + (r_pt[0] ? r_gq[v] : -r_gq[v]);
            deta[v] = $signed({{2{beta[v][33]}}, beta[v], 28'd0})
                    + (r_pt[1] ? r_gq[v] : -r_gq[v]);
        end
    end

    // operand table: v = 0 x, 1 y, 2 ux, 3 uy
    always_comb begin
        m_a   = '0;
        m_b   = '0;
        m_sub = 1'b0;
        m_clr = 1'b0;
        unique case (r_op)
            OP_GQ0, OP_GQ1, OP_GQ2, OP_GQ3: begin
                m_a   = {{30{tw[r_op[1:0]][33]}}, tw[r_op[1:0]]};
                m_b   = G28;
                m_clr = 1'b1;
            end
            OP_DET0: begin m_a = dxi[0];  m_b = deta[1]; m_clr = 1'b1; end
            OP_DET1: begin m_a = dxi[1];  m_b = deta[0]; m_sub = 1'b1; end
            OP_NXX0: begin m_a = deta[1]; m_b = dxi[2];  m_clr = 1'b1; end
            OP_NXX1: begin m_a = dxi[1];  m_b = deta[2]; m_sub = 1'b1; end
            OP_NYY0: begin m_a = dxi[0];  m_b = deta[3]; m_clr = 1'b1; end
            OP_NYY1: begin m_a = deta[0]; m_b = dxi[3];  m_sub = 1'b1; end
            OP_NG0:  begin m_a = dxi[0];  m_b = deta[2]; m_clr = 1'b1; end
            OP_NG1:  begin m_a = deta[0]; m_b = dxi[2];  m_sub = 1'b1; end
            OP_NG2:  begin m_a = deta[1]; m_b = dxi[3];  end
            OP_NG3:  begin m_a = dxi[1];  m_b = deta[3]; m_sub = 1'b1; end
            OP_SQXX: begin
                m_a = {{16{r_exx[47]}}, r_exx}; m_b = m_a; m_clr = 1'b1;
            end
            OP_SQYY: begin
                m_a = {{16{r_eyy[47]}}, r_eyy}; m_b = m_a; m_clr = 1'b1;
            end
            OP_SQXY: begin
                m_a = {{16{r_exx[47]}}, r_exx}; m_b = {{16{r_eyy[47]}}, r_eyy};
                m_clr = 1'b1;
            end
            OP_SQG: begin
                m_a = {{16{r_gxy[47]}}, r_gxy}; m_b = m_a; m_clr = 1'b1;
            end
            OP_EN0: begin m_a = {{32{r_d11[31]}}, r_d11}; m_b = r_t[0]; m_clr = 1'b1; end
            OP_EN1: begin m_a = {{32{r_d11[31]}}, r_d11}; m_b = r_t[1]; end
            OP_EN2, OP_EN3: begin m_a = {{32{r_d12[31]}}, r_d12}; m_b = r_t[2]; end
            OP_EN4: begin m_a = {{32{r_d33[31]}}, r_d33}; m_b = r_t[3]; end
            default: begin end
        endcase
    end

    always_comb begin
        pa   = r_pc[0] ? r_ma[63:32] : r_ma[31:0];
        pb   = r_pc[1] ? r_mb[63:32] : r_mb[31:0];
        pext = {64'd0, r_pp} << {r_psh, 5'd0};
        padd = r_msg ? -pext : pext;

        d_r2  = {r_dr, r_dn[127]};
        d_ge  = (d_r2 >= {1'b0, r_dd});
        d_sub = d_r2 - {1'b0, r_dd};
        d_qn  = {r_dq[60:0], d_ge};
        d_qs  = r_dsat ? {2'd0, GP_LIM} : {2'd0, r_dq};
        if (r_dneg) begin
            d_qs = -d_qs;
        end

        tot_sh = $signed(r_acc) >>> (FRAC_BITS + 1);
        if (tot_sh[127]) begin
            energy = '0;
        end else if (|tot_sh[126:ENERGY_W]) begin
            energy = '1;
        end else begin
            energy = tot_sh[ENERGY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_GQ0;
            r_cnt   <= '0;
            r_pt    <= '0;
            r_valid <= 1'b0;
            r_d11   <= '0;
            r_d12   <= '0;
            r_d33   <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NORMAL: r_d11 <= i_cfg_wdata;
                    CFG_CROSS:  r_d12 <= i_cfg_wdata;
                    CFG_SHEAR:  r_d33 <= i_cfg_wdata;
                    default: begin end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_nv[0][r_cnt] <= i_node_x;
                        r_nv[1][r_cnt] <= i_node_y;
                        r_nv[2][r_cnt] <= i_disp_x;
                        r_nv[3][r_cnt] <= i_disp_y;
                        r_cnt <= r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            r_last  <= i_last_of_mesh;
                            r_degen <= 1'b0;
                            r_sxx   <= '0;
                            r_syy   <= '0;
                            r_sg    <= '0;
                            r_pt    <= '0;
                            r_op    <= OP_GQ0;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    r_ma  <= mag64(m_a);
                    r_mb  <= mag64(m_b);
                    r_msg <= m_a[63] ^ m_b[63] ^ m_sub;
                    r_pc  <= '0;
                    if (m_clr) begin
                        r_acc <= '0;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pp  <= pa * pb;
                    r_psh <= 2'(r_pc[0]) + 2'(r_pc[1]);
                    if (r_pc != 3'd0) begin
                        r_acc <= r_acc + padd;
                    end
                    r_pc <= r_pc + 3'd1;
                    if (r_pc == 3'd4) begin
                        r_state <= S_AFTER;
                    end
                end
                S_AFTER: begin
                    unique case (r_op)
                        OP_GQ0, OP_GQ1, OP_GQ2, OP_GQ3: begin
                            r_gq[r_op[1:0]] <= r_acc[63:0];
                            r_op    <= t_op'(5'(r_op) + 5'd1);
                            r_state <= S_ISSUE;
                        end
                        OP_DET0, OP_NXX0, OP_NYY0, OP_NG0, OP_NG1, OP_NG2,
                        OP_EN0, OP_EN1, OP_EN2, OP_EN3: begin
                            r_op    <= t_op'(5'(r_op) + 5'd1);
                            r_state <= S_ISSUE;
                        end
                        OP_DET1: begin
                            r_det <= r_acc;
                            if (r_acc == '0) begin
                                r_degen <= 1'b1;
                                if (r_pt == 2'd3) begin
                                    r_state <= S_AVG;
                                end else begin
                                    r_pt    <= r_pt + 2'd1;
                                    r_op    <= OP_DET0;
                                    r_state <= S_ISSUE;
                                end
                            end else begin
                                r_op    <= OP_NXX0;
                                r_state <= S_ISSUE;
                            end
                        end
                        OP_NXX1, OP_NYY1, OP_NG3: begin
                            r_dn    <= r_acc[127] ? -r_acc : r_acc;
                            r_dd    <= r_det[127] ? -r_det : r_det;
                            r_dneg  <= r_acc[127] ^ r_det[127];
                            r_dr    <= '0;
                            r_dq    <= '0;
                            r_dsat  <= 1'b0;
                            r_dk    <= '0;
                            r_state <= S_DIV;
                        end
                        OP_SQXX, OP_SQYY, OP_SQXY, OP_SQG: begin
                            r_t[r_op[1:0] - 2'(OP_SQXX)] <= r_acc[95:32];
                            r_op    <= t_op'(5'(r_op) + 5'd1);
                            r_state <= S_ISSUE;
                        end
                        OP_EN4: begin
                            r_oxx   <= r_exx;
                            r_oyy   <= r_eyy;
                            r_oen   <= energy;
                            r_odeg  <= r_degen;
                            r_odone <= r_last;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_DIV: begin
                    r_dn <= r_dn << 1;
                    r_dr <= d_ge ? d_sub[127:0] : d_r2[127:0];
                    if (!r_dsat) begin
                        r_dq <= d_qn;
                        if (d_qn > GP_LIM) begin
                            r_dsat <= 1'b1;
                        end
                    end
                    r_dk <= r_dk + 8'd1;
                    if (r_dk == 8'd159) begin
                        r_state <= S_DACC;
                    end
                end
                S_DACC: begin
                    r_state <= S_ISSUE;
                    priority case (r_op)
                        OP_NXX1: begin
                            r_sxx <= r_sxx + $signed(d_qs);
                            r_op  <= OP_NYY0;
                        end
                        OP_NYY1: begin
                            r_syy <= r_syy + $signed(d_qs);
                            r_op  <= OP_NG0;
                        end
                        default: begin
                            r_sg <= r_sg + $signed(d_qs);
                            if (r_pt == 2'd3) begin
                                r_state <= S_AVG;
                            end else begin
                                r_pt <= r_pt + 2'd1;
                                r_op <= OP_DET0;
                            end
                        end
                    endcase
                end
                S_AVG: begin
                    r_exx   <= sat48(r_sxx);
                    r_eyy   <= sat48(r_syy);
                    r_gxy   <= sat48(r_sg);
                    r_op    <= OP_SQXX;
                    r_state <= S_ISSUE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/qese_checker.sv @@
`include "quad_element_strain_energy_assert.svh"

module qese_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        busy,
    input logic                        o_valid
);

    `QESE_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "result strobe longer than one cycle")
    `QESE_ASSERT_NOW(a_valid_idle, o_valid, !busy, "result shown while still busy")
    `QESE_ASSERT_NOW(a_valid_after_work, o_valid, $past(busy), "result without evaluation")
    `QESE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n, !busy && !o_valid, "not idle after reset")

endmodule

bind quad_element_strain_energy qese_checker u_qese_checker (.*);
